>>> sv/tbws_pkg.sv
// Shared types and constants of the beacon wake scheduler.
// Used by tbws_ctrl, tbws_dpath and tdma_beacon_wake_scheduler; depends on nothing.
package tbws_pkg;

	localparam int CFG_W       = 22;
	localparam int CFG_IDX_W   = 3;
	localparam int US_PER_MS   = 1000;
	localparam int MIN_SLEEP_US = 100000;
	localparam int PROD_W      = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY  = 3'd4;

	localparam logic [CFG_W-1:0] FRAME_RST  = 22'd60000;
	localparam logic [CFG_W-1:0] WINDOW_RST = 22'd5000;
	localparam logic [CFG_W-1:0] FIRST_RST  = 22'd300000;
	localparam logic [CFG_W-1:0] SLOT_RST   = 22'd10000;
	localparam logic [CFG_W-1:0] RETRY_RST  = 22'd10000;

	localparam logic [1:0] KIND_MOTION = 2'd0;
	localparam logic [1:0] KIND_WAKE   = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] ACT_INIT   = 2'd0;
	localparam logic [1:0] ACT_LISTEN = 2'd1;
	localparam logic [1:0] ACT_TX     = 2'd2;
	localparam logic [1:0] ACT_SLEEP  = 2'd3;

	typedef enum logic [1:0] {
		MODE_FIRST  = 2'd0,
		MODE_LISTEN = 2'd1,
		MODE_TX     = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_WAKE_OUT,
		ST_RETRY_MUL,
		ST_SLOT_MUL,
		ST_ADD_WAKE,
		ST_PER_MUL,
		ST_HALF_MUL,
		ST_PROJ,
		ST_CMP,
		ST_DIV,
		ST_FIX,
		ST_WNEXT,
		ST_SLEEP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SET_BEACON,
		OP_MUL_RETRY,
		OP_MUL_SLOT,
		OP_MUL_PERIOD,
		OP_MUL_HALF,
		OP_WAKE_PROD,
		OP_WAKE_HALF_FRAME,
		OP_PROJ_INIT,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_PROJ_FIX,
		OP_WAKE_NEXT,
		OP_WAKE_OUT,
		OP_SLEEP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] action;
		logic       light_valid;
		logic       light_on;
		logic       motion_wake_en;
		logic       radio_sleep;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       motion;
		logic       init_ok;
		logic       heard;
		logic       last_zero;
		logic       next_lt_target;
		logic       div_last;
		logic       out_free;
	} dp_stat_t;

endpackage

>>> sv/tdma_beacon_wake_scheduler.sv
// Top level of the beacon-synchronised TDMA sleep and wake scheduler.
// Instantiates tbws_ctrl and tbws_dpath; depends on tbws_pkg.
//
// Each input beat is one event (motion wake, timer wake or round-done report)
// and produces one result beat, except a beat of kind 3, which is consumed
// silently. One event is handled at a time: s_tready is high only while the
// block is idle, and a finished result waits in the output register while the
// next beat is taken. A motion or timer wake goes straight to its result, as
// does a report that only goes back to sleep; a round-done report that
// schedules the transmit slot or a retry first multiplies and adds, and one
// that projects the next beacon multiplies the period and half window and
// may run the bit-serial remainder unit, which steps one bit of the beacon
// distance per cycle. A result is held back until the output register is
// free. Configuration writes land at once and are to be made while no event
// is in flight.
module tdma_beacon_wake_scheduler #(
	parameter int TIME_BITS = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wen,
	input  logic [tbws_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tbws_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// now_us, motion_level, init_ok, beacon_heard, zero padding
	input  logic [((TIME_BITS+3+7)/8)*8-1:0]      s_tdata,
	// kind
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// listen_window_ms, light_valid, light_on, next_wake_us, sleep_us,
	// motion_wake_enabled, wake_level, radio_sleep_cmd, zero padding
	output logic [((2*TIME_BITS+27+7)/8)*8-1:0]   m_tdata,
	// action
	output logic [1:0]                            m_tuser
);
	import tbws_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	tbws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tbws_dpath #(
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

`ifndef ASSERT_OFF
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Scheduler took a beat while still busy.");

	a_sleep_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_SLEEP |->
		m_tdata[2*TIME_BITS+23:TIME_BITS+24] >= TIME_BITS'(MIN_SLEEP_US))
		else $error("Sleep duration below the minimum.");

	a_wake_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ACT_SLEEP |-> m_tdata[2*TIME_BITS+26:CFG_W] == '0)
		else $error("Wake result carries sleep fields.");
`endif

endmodule

>>> sv/tbws_ctrl.sv
// Controller of the beacon wake scheduler: sequencing state machine and node flags.
// Depends on tbws_pkg; drives tbws_dpath through a command struct.
module tbws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tbws_pkg::dp_stat_t stat,
	output tbws_pkg::ctl_cmd_t cmd
);
	import tbws_pkg::*;

	state_t state_q, state_d;
	mode_t  rm_q, rm_d;
	logic   ready_q, ready_d;
	logic   asleep_q, asleep_d;
	logic   txp_q, txp_d;
	logic   armed_q, armed_d;
	logic   lvl_q, lvl_d;
	logic   lv_q, lv_d;
	logic   lon_q, lon_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rm_q     <= MODE_FIRST;
			ready_q  <= 1'b0;
			asleep_q <= 1'b0;
			txp_q    <= 1'b0;
			armed_q  <= 1'b0;
			lvl_q    <= 1'b0;
			lv_q     <= 1'b0;
			lon_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			rm_q     <= rm_d;
			ready_q  <= ready_d;
			asleep_q <= asleep_d;
			txp_q    <= txp_d;
			armed_q  <= armed_d;
			lvl_q    <= lvl_d;
			lv_q     <= lv_d;
			lon_q    <= lon_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		rm_d     = rm_q;
		ready_d  = ready_q;
		asleep_d = asleep_q;
		txp_d    = txp_q;
		armed_d  = armed_q;
		lvl_d    = lvl_q;
		lv_d     = lv_q;
		lon_d    = lon_q;
		cmd.op             = OP_NONE;
		cmd.action         = ACT_INIT;
		cmd.light_valid    = 1'b0;
		cmd.light_on       = 1'b0;
		cmd.motion_wake_en = 1'b0;
		cmd.radio_sleep    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.kind)
					KIND_MOTION: begin
						lv_d    = 1'b1;
						lon_d   = !lvl_q;
						state_d = ST_SLEEP;
					end
					KIND_WAKE: begin
						state_d = ST_WAKE_OUT;
					end
					KIND_DONE: begin
						rm_d  = MODE_NONE;
						lv_d  = 1'b0;
						lon_d = 1'b0;
						if (rm_q == MODE_FIRST && !stat.init_ok) begin
							state_d = ST_RETRY_MUL;
						end else begin
							if (rm_q == MODE_FIRST) begin
								ready_d  = 1'b1;
								asleep_d = 1'b0;
							end
							if ((rm_q == MODE_FIRST || rm_q == MODE_LISTEN) && stat.heard) begin
								txp_d   = 1'b1;
								cmd.op  = OP_SET_BEACON;
								state_d = ST_SLOT_MUL;
							end else if (txp_q) begin
								state_d = ST_SLEEP;
							end else begin
								state_d = ST_PER_MUL;
							end
						end
					end
					KIND_NONE: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_WAKE_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_WAKE_OUT;
					state_d = ST_IDLE;
					if (!ready_q) begin
						rm_d       = MODE_FIRST;
						cmd.action = ACT_INIT;
					end else begin
						asleep_d = 1'b0;
						armed_d  = 1'b1;
						if (txp_q) begin
							txp_d      = 1'b0;
							rm_d       = MODE_TX;
							cmd.action = ACT_TX;
						end else begin
							rm_d       = MODE_LISTEN;
							cmd.action = ACT_LISTEN;
						end
					end
				end
			end
			ST_RETRY_MUL: begin
				cmd.op  = OP_MUL_RETRY;
				state_d = ST_ADD_WAKE;
			end
			ST_SLOT_MUL: begin
				cmd.op  = OP_MUL_SLOT;
				state_d = ST_ADD_WAKE;
			end
			ST_ADD_WAKE: begin
				cmd.op  = OP_WAKE_PROD;
				state_d = ST_SLEEP;
			end
			ST_PER_MUL: begin
				cmd.op  = OP_MUL_PERIOD;
				state_d = ST_HALF_MUL;
			end
			ST_HALF_MUL: begin
				cmd.op  = OP_MUL_HALF;
				state_d = ST_PROJ;
			end
			ST_PROJ: begin
				if (stat.last_zero) begin
					cmd.op  = OP_WAKE_HALF_FRAME;
					state_d = ST_SLEEP;
				end else begin
					cmd.op  = OP_PROJ_INIT;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (stat.next_lt_target) begin
					cmd.op  = OP_DIV_START;
					state_d = ST_DIV;
				end else begin
					cmd.op  = OP_WAKE_NEXT;
					state_d = ST_SLEEP;
				end
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_last) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.op  = OP_PROJ_FIX;
				state_d = ST_WNEXT;
			end
			ST_WNEXT: begin
				cmd.op  = OP_WAKE_NEXT;
				state_d = ST_SLEEP;
			end
			ST_SLEEP: begin
				if (stat.out_free) begin
					cmd.op             = OP_SLEEP_OUT;
					cmd.action         = ACT_SLEEP;
					cmd.light_valid    = lv_q;
					cmd.light_on       = lon_q;
					cmd.motion_wake_en = armed_q;
					cmd.radio_sleep    = !asleep_q;
					lvl_d              = stat.motion;
					asleep_d           = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> sv/tbws_dpath.sv
// Datapath of the beacon wake scheduler: configuration, time registers, the
// millisecond multiplier, the bit-serial remainder unit and the result register.
// Depends on tbws_pkg; commanded by tbws_ctrl.
module tbws_dpath #(
	parameter int TIME_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [tbws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbws_pkg::CFG_W-1:0]      cfg_data,
	input  logic [((TIME_BITS+3+7)/8)*8-1:0] s_tdata,
	input  logic [1:0]                      s_tuser,
	input  tbws_pkg::ctl_cmd_t              cmd,
	output tbws_pkg::dp_stat_t              stat,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [((2*TIME_BITS+27+7)/8)*8-1:0] m_tdata,
	output logic [1:0]                      m_tuser
);
	import tbws_pkg::*;

	localparam int OUT_W = ((2*TIME_BITS+27+7)/8)*8;
	localparam int EW    = (TIME_BITS + 2 > 64) ? 64 : TIME_BITS + 2;
	localparam int CNT_W = $clog2(EW + 1);

	logic [CFG_W-1:0] frame_q, window_q, first_q, slot_q, retry_q;

	logic [1:0]           kind_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 motion_q, init_ok_q, heard_q;

	logic [TIME_BITS-1:0] last_q, wake_q;
	logic [PROD_W-1:0]    prod_q, period_q, half_q;
	logic [EW-1:0]        next_q, target_q, d_q;
	logic [PROD_W-1:0]    r_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;
	logic [1:0]           out_user_q;

	logic [CFG_W-1:0]     mul_a;
	logic [PROD_W-1:0]    mul_p;
	logic [PROD_W:0]      r_shift;
	logic [PROD_W:0]      r_sub;
	logic [TIME_BITS-1:0] rem_raw, rem;
	logic [OUT_W-1:0]     wake_data, sleep_data;
	logic                 out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= FRAME_RST;
			window_q <= WINDOW_RST;
			first_q  <= FIRST_RST;
			slot_q   <= SLOT_RST;
			retry_q  <= RETRY_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_FRAME:  frame_q  <= cfg_data;
				CFG_WINDOW: window_q <= cfg_data;
				CFG_FIRST:  first_q  <= cfg_data;
				CFG_SLOT:   slot_q   <= cfg_data;
				CFG_RETRY:  retry_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.op)
			OP_MUL_RETRY:  mul_a = retry_q;
			OP_MUL_SLOT:   mul_a = slot_q;
			OP_MUL_PERIOD: mul_a = (frame_q == '0) ? CFG_W'(1) : frame_q;
			OP_MUL_HALF:   mul_a = window_q;
			default:       mul_a = '0;
		endcase
		mul_p = PROD_W'(mul_a) * PROD_W'(US_PER_MS);
	end

	assign r_shift = {r_q, d_q[EW-1]};
	assign r_sub   = r_shift - {1'b0, period_q};

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q    <= s_tuser;
				now_q     <= s_tdata[TIME_BITS-1:0];
				motion_q  <= s_tdata[TIME_BITS];
				init_ok_q <= s_tdata[TIME_BITS+1];
				heard_q   <= s_tdata[TIME_BITS+2];
			end
			OP_MUL_RETRY, OP_MUL_SLOT: prod_q <= mul_p;
			OP_MUL_PERIOD: period_q <= mul_p;
			OP_MUL_HALF:   half_q   <= {1'b0, mul_p[PROD_W-1:1]};
			OP_PROJ_INIT: begin
				next_q   <= EW'(last_q) + EW'(period_q);
				target_q <= EW'(now_q) + EW'(half_q);
			end
			OP_DIV_START: begin
				d_q   <= target_q - next_q;
				r_q   <= '0;
				cnt_q <= CNT_W'(EW);
			end
			OP_DIV_STEP: begin
				d_q   <= {d_q[EW-2:0], 1'b0};
				r_q   <= r_sub[PROD_W] ? r_shift[PROD_W-1:0] : r_sub[PROD_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_PROJ_FIX: begin
				next_q <= target_q + ((r_q == '0) ? EW'(0) : EW'(period_q - r_q));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			wake_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_SET_BEACON:      last_q <= now_q;
				OP_WAKE_PROD:       wake_q <= now_q + TIME_BITS'(prod_q);
				OP_WAKE_HALF_FRAME: wake_q <= now_q + TIME_BITS'(period_q >> 1);
				OP_WAKE_NEXT:       wake_q <= TIME_BITS'(next_q - EW'(half_q));
				default: ;
			endcase
		end
	end

	always_comb begin
		rem_raw = (wake_q > now_q) ? wake_q - now_q : '0;
		rem     = (rem_raw < TIME_BITS'(MIN_SLEEP_US)) ? TIME_BITS'(MIN_SLEEP_US) : rem_raw;

		wake_data = '0;
		unique case (cmd.action)
			ACT_INIT:   wake_data[CFG_W-1:0] = first_q;
			ACT_LISTEN: wake_data[CFG_W-1:0] = window_q;
			default:    wake_data[CFG_W-1:0] = '0;
		endcase

		sleep_data = '0;
		sleep_data[CFG_W]                            = cmd.light_valid;
		sleep_data[CFG_W+1]                          = cmd.light_on;
		sleep_data[CFG_W+2 +: TIME_BITS]             = wake_q;
		sleep_data[CFG_W+2+TIME_BITS +: TIME_BITS]   = rem;
		sleep_data[CFG_W+2+2*TIME_BITS]              = cmd.motion_wake_en;
		sleep_data[CFG_W+3+2*TIME_BITS]              = !motion_q;
		sleep_data[CFG_W+4+2*TIME_BITS]              = cmd.radio_sleep;
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_WAKE_OUT || cmd.op == OP_SLEEP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WAKE_OUT) begin
			out_data_q <= wake_data;
			out_user_q <= cmd.action;
		end else if (cmd.op == OP_SLEEP_OUT) begin
			out_data_q <= sleep_data;
			out_user_q <= cmd.action;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	assign stat.kind           = kind_q;
	assign stat.motion         = motion_q;
	assign stat.init_ok        = init_ok_q;
	assign stat.heard          = heard_q;
	assign stat.last_zero      = (last_q == '0);
	assign stat.next_lt_target = (next_q < target_q);
	assign stat.div_last       = (cnt_q == CNT_W'(1));
	assign stat.out_free       = out_free;

endmodule
